// File: rtl/control_word_decoder_macros.svh
// Assertion macros for the control word decoder.
`ifndef CONTROL_WORD_DECODER_MACROS_SVH
`define CONTROL_WORD_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent property checked at every rising edge outside reset
`define CWD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("control_word_decoder: property violated");

// Expression that must never be true outside reset
`define CWD_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("control_word_decoder: forbidden condition seen");

`else

`define CWD_ASSERT(label, clk, rst_n, prop)
`define CWD_NEVER(label, clk, rst_n, expr)

`endif

`endif

// File: rtl/cwd_pkg.sv
package cwd_pkg;

    // Load strobe bit positions
    localparam int unsigned LD_A   = 0;
    localparam int unsigned LD_B   = 1;
    localparam int unsigned LD_F   = 2;
    localparam int unsigned LD_IR  = 3;
    localparam int unsigned LD_PC  = 4;
    localparam int unsigned LD_MAR = 5;
    localparam int unsigned LD_OUT = 6;

    // Bus drive bit positions
    localparam int unsigned DR_F   = 2;
    localparam int unsigned DR_PC  = 4;
    localparam int unsigned DR_MEM = 5;
    localparam int unsigned DR_IN  = 6;

    // Timing steps
    localparam logic [3:0] STEP_FETCH_ADDR = 4'd0;
    localparam logic [3:0] STEP_FETCH_DATA = 4'd1;
    localparam logic [3:0] STEP_EXEC_2     = 4'd2;
    localparam logic [3:0] STEP_EXEC_3     = 4'd3;
    localparam logic [3:0] STEP_EXEC_4     = 4'd4;
    localparam logic [3:0] STEP_EXEC_5     = 4'd5;
    localparam logic [3:0] STEP_EXEC_6     = 4'd6;

    // Opcodes
    localparam logic [7:0] OP_NOP       = 8'h00;
    localparam logic [7:0] OP_IN_OUT    = 8'h01;
    localparam logic [7:0] OP_IN_A      = 8'h02;
    localparam logic [7:0] OP_IN_B      = 8'h03;
    localparam logic [7:0] OP_F_A       = 8'h04;
    localparam logic [7:0] OP_F_B       = 8'h05;
    localparam logic [7:0] OP_ALU_8     = 8'h06;
    localparam logic [7:0] OP_ALU_9     = 8'h07;
    localparam logic [7:0] OP_F_OUT     = 8'h08;
    localparam logic [7:0] OP_LD_A      = 8'h09;
    localparam logic [7:0] OP_LD_B      = 8'h0a;
    localparam logic [7:0] OP_LD_OUT    = 8'h0b;
    localparam logic [7:0] OP_ALU_FIRST = 8'h0c;
    localparam logic [7:0] OP_ALU_LAST  = 8'h1d;
    localparam logic [7:0] OP_MEM_ADD   = 8'h1f;
    localparam logic [7:0] OP_MEM_SUB   = 8'h20;
    localparam logic [7:0] OP_JUMP      = 8'h21;
    localparam logic [7:0] OP_HALT      = 8'h22;

    // ALU operation codes
    localparam logic [4:0] ALU_ADD = 5'd0;
    localparam logic [4:0] ALU_SUB = 5'd1;
    localparam logic [4:0] ALU_OP8 = 5'd8;
    localparam logic [4:0] ALU_OP9 = 5'd9;

    localparam int unsigned ALU_TABLE_DEPTH = 18;

    // ALU codes for the single-step ALU opcodes, indexed by opcode - 0x0c
    localparam logic [4:0] ALU_CODES [ALU_TABLE_DEPTH] = '{
        5'd0,  5'd1,  5'd4,  5'd5,  5'd2,  5'd3,  5'd6,  5'd7,  5'd8,
        5'd9,  5'd10, 5'd11, 5'd16, 5'd15, 5'd17, 5'd18, 5'd20, 5'd20
    };

    // One control word
    typedef struct packed {
        logic [7:0] reg_load;
        logic [6:0] bus_drive;
        logic       mem_write;
        logic       pc_increment;
        logic       pc_halt;
        logic       step_reset;
        logic [4:0] alu_op;
    } ctrl_word_t;

    // Full control word decode for one opcode and step
    function automatic ctrl_word_t decode_word(input logic [7:0] opc,
                                               input logic [3:0] stp);
        ctrl_word_t w;
        logic [7:0] rel;
        logic [4:0] idx;
        w   = '0;
        rel = opc - OP_ALU_FIRST;
        idx = rel[4:0];
        if (stp == STEP_FETCH_ADDR)
        begin
            w.reg_load[LD_MAR] = 1'b1;
            w.bus_drive[DR_PC] = 1'b1;
        end
        else if (stp == STEP_FETCH_DATA)
        begin
            w.reg_load[LD_IR]   = 1'b1;
            w.bus_drive[DR_MEM] = 1'b1;
            w.pc_increment      = 1'b1;
        end
        else
        begin
            unique case (opc) inside
                [OP_NOP:OP_F_OUT]:
                begin
                    if (stp == STEP_EXEC_2)
                    begin
                        w.step_reset = 1'b1;
                        unique case (opc)
                            OP_NOP:
                            begin
                            end
                            OP_IN_OUT:
                            begin
                                w.reg_load[LD_OUT] = 1'b1;
                                w.bus_drive[DR_IN] = 1'b1;
                            end
                            OP_IN_A:
                            begin
                                w.reg_load[LD_A]   = 1'b1;
                                w.bus_drive[DR_IN] = 1'b1;
                            end
                            OP_IN_B:
                            begin
                                w.reg_load[LD_B]   = 1'b1;
                                w.bus_drive[DR_IN] = 1'b1;
                            end
                            OP_F_A:
                            begin
                                w.reg_load[LD_A]  = 1'b1;
                                w.bus_drive[DR_F] = 1'b1;
                            end
                            OP_F_B:
                            begin
                                w.reg_load[LD_B]  = 1'b1;
                                w.bus_drive[DR_F] = 1'b1;
                            end
                            OP_ALU_8:
                            begin
                                w.reg_load[LD_F] = 1'b1;
                                w.alu_op         = ALU_OP8;
                            end
                            OP_ALU_9:
                            begin
                                w.reg_load[LD_F] = 1'b1;
                                w.alu_op         = ALU_OP9;
                            end
                            default:
                            begin
                                w.reg_load[LD_OUT] = 1'b1;
                                w.bus_drive[DR_F]  = 1'b1;
                            end
                        endcase
                    end
                end
                [OP_LD_A:OP_LD_OUT]:
                begin
                    if (stp == STEP_EXEC_2)
                    begin
                        w.reg_load[LD_MAR] = 1'b1;
                        w.bus_drive[DR_PC] = 1'b1;
                    end
                    else if (stp == STEP_EXEC_3)
                    begin
                        w.reg_load[LD_A]    = (opc == OP_LD_A);
                        w.reg_load[LD_B]    = (opc == OP_LD_B);
                        w.reg_load[LD_OUT]  = (opc == OP_LD_OUT);
                        w.bus_drive[DR_MEM] = 1'b1;
                        w.pc_increment      = 1'b1;
                        w.step_reset        = 1'b1;
                    end
                end
                [OP_ALU_FIRST:OP_ALU_LAST]:
                begin
                    if (stp == STEP_EXEC_2)
                    begin
                        w.reg_load[LD_F] = 1'b1;
                        w.step_reset     = 1'b1;
                        w.alu_op         = ALU_CODES[idx];
                    end
                end
                OP_MEM_ADD, OP_MEM_SUB:
                begin
                    unique case (stp)
                        STEP_EXEC_2, STEP_EXEC_4:
                        begin
                            w.reg_load[LD_MAR] = 1'b1;
                            w.bus_drive[DR_PC] = 1'b1;
                        end
                        STEP_EXEC_3:
                        begin
                            w.reg_load[LD_A]    = 1'b1;
                            w.bus_drive[DR_MEM] = 1'b1;
                            w.pc_increment      = 1'b1;
                        end
                        STEP_EXEC_5:
                        begin
                            w.reg_load[LD_B]    = 1'b1;
                            w.bus_drive[DR_MEM] = 1'b1;
                            w.pc_increment      = 1'b1;
                        end
                        STEP_EXEC_6:
                        begin
                            w.reg_load[LD_F] = 1'b1;
                            w.step_reset     = 1'b1;
                            w.alu_op         = (opc == OP_MEM_ADD) ? ALU_ADD : ALU_SUB;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_JUMP:
                begin
                    if (stp == STEP_EXEC_2)
                    begin
                        w.reg_load[LD_MAR] = 1'b1;
                        w.bus_drive[DR_PC] = 1'b1;
                    end
                    else if (stp == STEP_EXEC_3)
                    begin
                        w.reg_load[LD_PC]   = 1'b1;
                        w.bus_drive[DR_MEM] = 1'b1;
                        w.step_reset        = 1'b1;
                    end
                end
                OP_HALT:
                begin
                    if (stp == STEP_EXEC_2)
                    begin
                        w.pc_halt    = 1'b1;
                        w.step_reset = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        return w;
    endfunction

endpackage

// File: rtl/control_word_decoder.sv
// Channel   Handshake            Payload
// -------   ------------------   -----------------------------------------------
// command   start / busy         opcode, step
// result    done (one cycle)     reg_load, bus_drive, mem_write, pc_increment,
//                                pc_halt, step_reset, alu_op
//
// Each transaction passes through the input register, then through the decode
// into the result register, before done is raised.
// A new transaction is taken every cycle; busy is held low.
// The receiver cannot stall; done is high for exactly one cycle per transaction.
// rst_n (asynchronous, active low) clears the valid flags only.
`include "control_word_decoder_macros.svh"

module control_word_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] opcode,
    input  logic [3:0] step,
    output logic       done,
    output logic [7:0] reg_load,
    output logic [6:0] bus_drive,
    output logic       mem_write,
    output logic       pc_increment,
    output logic       pc_halt,
    output logic       step_reset,
    output logic [4:0] alu_op
);

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [7:0]          opcode_reg;
    logic [3:0]          step_reg;
    logic                done_reg;
    cwd_pkg::ctrl_word_t word_reg;
    cwd_pkg::ctrl_word_t word_next;

    // Never stalls
    assign busy = 1'b0;

    assign in_valid_next = start && !busy;

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            done_reg     <= in_valid_reg;
        end
    end

    // Input payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid_next) begin
            opcode_reg <= opcode;
            step_reg   <= step;
        end
    end

    // Decode
    always_comb
    begin
        word_next = cwd_pkg::decode_word(opcode_reg, step_reg);
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (in_valid_reg) begin
            word_reg <= word_next;
        end
    end

    assign done         = done_reg;
    assign reg_load     = word_reg.reg_load;
    assign bus_drive    = word_reg.bus_drive;
    assign mem_write    = word_reg.mem_write;
    assign pc_increment = word_reg.pc_increment;
    assign pc_halt      = word_reg.pc_halt;
    assign step_reset   = word_reg.step_reset;
    assign alu_op       = word_reg.alu_op;

    // Checks
    `CWD_ASSERT(a_latency, clk, rst_n, (start && !busy) |=> ##1 done)
    `CWD_ASSERT(a_no_spurious, clk, rst_n, !(start && !busy) |=> ##1 !done)
    `CWD_ASSERT(a_halt_ends, clk, rst_n, (done && pc_halt) |-> step_reset)
    `CWD_NEVER(a_inc_mem, clk, rst_n, done && pc_increment && !bus_drive[cwd_pkg::DR_MEM])

endmodule

// File: bench/cwd_checker.sv
`timescale 1ns / 1ps

module cwd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [7:0]  opcode,
    input  logic [3:0]  step,
    input  logic        done,
    input  logic [7:0]  reg_load,
    input  logic [6:0]  bus_drive,
    input  logic        mem_write,
    input  logic        pc_increment,
    input  logic        pc_halt,
    input  logic        step_reset,
    input  logic [4:0]  alu_op,
    output int unsigned fail_count,
    output int unsigned pending
);

    // ALU codes of the single-step ALU opcodes, indexed by opcode - first ALU opcode
    localparam logic [4:0] ALU_BY_OPCODE [18] = '{
        5'd0,  5'd1,  5'd4,  5'd5,  5'd2,  5'd3,  5'd6,  5'd7,  5'd8,
        5'd9,  5'd10, 5'd11, 5'd16, 5'd15, 5'd17, 5'd18, 5'd20, 5'd20
    };

    // Control word expected for one opcode and timing step
    function automatic cwd_pkg::ctrl_word_t predict_control(input logic [7:0] opc,
                                                            input logic [3:0] stp);
        cwd_pkg::ctrl_word_t w;
        logic [7:0]          rel;
        w   = '0;
        rel = opc - cwd_pkg::OP_ALU_FIRST;
        if (stp == cwd_pkg::STEP_FETCH_ADDR)
        begin
            w.reg_load[cwd_pkg::LD_MAR] = 1'b1;
            w.bus_drive[cwd_pkg::DR_PC] = 1'b1;
        end
        else if (stp == cwd_pkg::STEP_FETCH_DATA)
        begin
            w.reg_load[cwd_pkg::LD_IR]   = 1'b1;
            w.bus_drive[cwd_pkg::DR_MEM] = 1'b1;
            w.pc_increment               = 1'b1;
        end
        else if (opc <= cwd_pkg::OP_F_OUT)
        begin
            // register moves and two-code ALU ops, all done in step 2
            if (stp == cwd_pkg::STEP_EXEC_2)
            begin
                w.step_reset = 1'b1;
                case (opc)
                    cwd_pkg::OP_IN_OUT:
                    begin
                        w.reg_load[cwd_pkg::LD_OUT] = 1'b1;
                        w.bus_drive[cwd_pkg::DR_IN] = 1'b1;
                    end
                    cwd_pkg::OP_IN_A:
                    begin
                        w.reg_load[cwd_pkg::LD_A]   = 1'b1;
                        w.bus_drive[cwd_pkg::DR_IN] = 1'b1;
                    end
                    cwd_pkg::OP_IN_B:
                    begin
                        w.reg_load[cwd_pkg::LD_B]   = 1'b1;
                        w.bus_drive[cwd_pkg::DR_IN] = 1'b1;
                    end
                    cwd_pkg::OP_F_A:
                    begin
                        w.reg_load[cwd_pkg::LD_A]  = 1'b1;
                        w.bus_drive[cwd_pkg::DR_F] = 1'b1;
                    end
                    cwd_pkg::OP_F_B:
                    begin
                        w.reg_load[cwd_pkg::LD_B]  = 1'b1;
                        w.bus_drive[cwd_pkg::DR_F] = 1'b1;
                    end
                    cwd_pkg::OP_ALU_8:
                    begin
                        w.reg_load[cwd_pkg::LD_F] = 1'b1;
                        w.alu_op                  = cwd_pkg::ALU_OP8;
                    end
                    cwd_pkg::OP_ALU_9:
                    begin
                        w.reg_load[cwd_pkg::LD_F] = 1'b1;
                        w.alu_op                  = cwd_pkg::ALU_OP9;
                    end
                    cwd_pkg::OP_F_OUT:
                    begin
                        w.reg_load[cwd_pkg::LD_OUT] = 1'b1;
                        w.bus_drive[cwd_pkg::DR_F]  = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (opc <= cwd_pkg::OP_LD_OUT)
        begin
            // memory operand into A, B or output port
            if (stp == cwd_pkg::STEP_EXEC_2)
            begin
                w.reg_load[cwd_pkg::LD_MAR] = 1'b1;
                w.bus_drive[cwd_pkg::DR_PC] = 1'b1;
            end
            else if (stp == cwd_pkg::STEP_EXEC_3)
            begin
                if (opc == cwd_pkg::OP_LD_A)
                    w.reg_load[cwd_pkg::LD_A] = 1'b1;
                else if (opc == cwd_pkg::OP_LD_B)
                    w.reg_load[cwd_pkg::LD_B] = 1'b1;
                else
                    w.reg_load[cwd_pkg::LD_OUT] = 1'b1;
                w.bus_drive[cwd_pkg::DR_MEM] = 1'b1;
                w.pc_increment               = 1'b1;
                w.step_reset                 = 1'b1;
            end
        end
        else if (opc <= cwd_pkg::OP_ALU_LAST)
        begin
            if (stp == cwd_pkg::STEP_EXEC_2)
            begin
                w.reg_load[cwd_pkg::LD_F] = 1'b1;
                w.step_reset              = 1'b1;
                w.alu_op                  = ALU_BY_OPCODE[rel[4:0]];
            end
        end
        else if (opc == cwd_pkg::OP_MEM_ADD || opc == cwd_pkg::OP_MEM_SUB)
        begin
            // two memory operands, then the ALU
            case (stp)
                cwd_pkg::STEP_EXEC_2, cwd_pkg::STEP_EXEC_4:
                begin
                    w.reg_load[cwd_pkg::LD_MAR] = 1'b1;
                    w.bus_drive[cwd_pkg::DR_PC] = 1'b1;
                end
                cwd_pkg::STEP_EXEC_3:
                begin
                    w.reg_load[cwd_pkg::LD_A]    = 1'b1;
                    w.bus_drive[cwd_pkg::DR_MEM] = 1'b1;
                    w.pc_increment               = 1'b1;
                end
                cwd_pkg::STEP_EXEC_5:
                begin
                    w.reg_load[cwd_pkg::LD_B]    = 1'b1;
                    w.bus_drive[cwd_pkg::DR_MEM] = 1'b1;
                    w.pc_increment               = 1'b1;
                end
                cwd_pkg::STEP_EXEC_6:
                begin
                    w.reg_load[cwd_pkg::LD_F] = 1'b1;
                    w.step_reset              = 1'b1;
                    w.alu_op                  = (opc == cwd_pkg::OP_MEM_ADD) ?
                                                cwd_pkg::ALU_ADD : cwd_pkg::ALU_SUB;
                end
                default:
                begin
                end
            endcase
        end
        else if (opc == cwd_pkg::OP_JUMP)
        begin
            if (stp == cwd_pkg::STEP_EXEC_2)
            begin
                w.reg_load[cwd_pkg::LD_MAR] = 1'b1;
                w.bus_drive[cwd_pkg::DR_PC] = 1'b1;
            end
            else if (stp == cwd_pkg::STEP_EXEC_3)
            begin
                w.reg_load[cwd_pkg::LD_PC]   = 1'b1;
                w.bus_drive[cwd_pkg::DR_MEM] = 1'b1;
                w.step_reset                 = 1'b1;
            end
        end
        else if (opc == cwd_pkg::OP_HALT)
        begin
            if (stp == cwd_pkg::STEP_EXEC_2)
            begin
                w.pc_halt    = 1'b1;
                w.step_reset = 1'b1;
            end
        end
        return w;
    endfunction

    // Returns 1 on a mismatch
    function automatic int field_bad(input string name, input int unsigned want,
                                     input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    cwd_pkg::ctrl_word_t expected_words [$];

    // Retire the oldest expectation on done, then record the new transaction
    always @(posedge clk or negedge rst_n)
    begin
        cwd_pkg::ctrl_word_t want;
        int                  bad;
        int                  delta;
        if (!rst_n)
        begin
            expected_words.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            bad   = 0;
            delta = 0;
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    bad = 1;
                end
                else
                begin
                    want  = expected_words.pop_front();
                    delta = delta - 1;
                    bad   = field_bad("reg_load", 32'(want.reg_load), 32'(reg_load))
                          + field_bad("bus_drive", 32'(want.bus_drive), 32'(bus_drive))
                          + field_bad("mem_write", 32'(want.mem_write), 32'(mem_write))
                          + field_bad("pc_increment", 32'(want.pc_increment),
                                      32'(pc_increment))
                          + field_bad("pc_halt", 32'(want.pc_halt), 32'(pc_halt))
                          + field_bad("step_reset", 32'(want.step_reset), 32'(step_reset))
                          + field_bad("alu_op", 32'(want.alu_op), 32'(alu_op));
                end
            end
            if (start && !busy)
            begin
                expected_words.push_back(predict_control(opcode, step));
                delta = delta + 1;
            end
            fail_count <= fail_count + bad;
            pending    <= pending + delta;
        end
    end

endmodule

// File: bench/tb_control_word_decoder.sv
`timescale 1ns / 1ps

module tb_control_word_decoder;

    localparam int          RANDOM_ITEMS  = 1800;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          DRAIN_CYCLES  = 4;
    localparam logic [7:0]  OP_UNLISTED   = 8'h1e;
    localparam logic [7:0]  OP_PAST_TABLE = 8'h23;
    localparam logic [7:0]  OP_TOP        = 8'hff;
    localparam logic [7:0]  OP_SHIFT      = cwd_pkg::OP_ALU_LAST - 8'd1;
    localparam logic [3:0]  STEP_LAST     = 4'hf;

    // Directed commands: {opcode, step}
    localparam logic [11:0] DIRECTED [25] = '{
        {cwd_pkg::OP_NOP, cwd_pkg::STEP_EXEC_2},
        {cwd_pkg::OP_IN_OUT, cwd_pkg::STEP_EXEC_2},
        {cwd_pkg::OP_IN_A, cwd_pkg::STEP_EXEC_2},
        {cwd_pkg::OP_IN_B, cwd_pkg::STEP_EXEC_2},
        {cwd_pkg::OP_F_A, cwd_pkg::STEP_EXEC_2},
        {cwd_pkg::OP_F_B, cwd_pkg::STEP_EXEC_2},
        {cwd_pkg::OP_ALU_8, cwd_pkg::STEP_EXEC_2},
        {cwd_pkg::OP_ALU_9, cwd_pkg::STEP_EXEC_2},
        {cwd_pkg::OP_F_OUT, cwd_pkg::STEP_EXEC_2},
        {cwd_pkg::OP_LD_A, cwd_pkg::STEP_EXEC_3},
        {cwd_pkg::OP_LD_B, cwd_pkg::STEP_EXEC_3},
        {cwd_pkg::OP_LD_OUT, cwd_pkg::STEP_EXEC_2},
        {cwd_pkg::OP_LD_OUT, cwd_pkg::STEP_EXEC_3},
        {cwd_pkg::OP_ALU_FIRST, cwd_pkg::STEP_EXEC_2},
        {OP_SHIFT, cwd_pkg::STEP_EXEC_2},
        {cwd_pkg::OP_ALU_LAST, cwd_pkg::STEP_EXEC_2},
        {OP_UNLISTED, cwd_pkg::STEP_EXEC_2},
        {cwd_pkg::OP_MEM_ADD, cwd_pkg::STEP_EXEC_6},
        {cwd_pkg::OP_MEM_SUB, cwd_pkg::STEP_EXEC_5},
        {cwd_pkg::OP_MEM_SUB, cwd_pkg::STEP_EXEC_6},
        {cwd_pkg::OP_JUMP, cwd_pkg::STEP_EXEC_3},
        {cwd_pkg::OP_HALT, cwd_pkg::STEP_EXEC_2},
        {OP_TOP, cwd_pkg::STEP_FETCH_ADDR},
        {OP_TOP, cwd_pkg::STEP_FETCH_DATA},
        {OP_PAST_TABLE, STEP_LAST}
    };

    logic        clk    = 1'b0;
    logic        rst_n  = 1'b0;
    logic        start  = 1'b0;
    logic [7:0]  opcode = '0;
    logic [3:0]  step   = '0;
    logic        busy;
    logic        done;
    logic [7:0]  reg_load;
    logic [6:0]  bus_drive;
    logic        mem_write;
    logic        pc_increment;
    logic        pc_halt;
    logic        step_reset;
    logic [4:0]  alu_op;
    int unsigned fail_count;
    int unsigned pending;
    int          cycles     = 0;
    int          burst_left = 0;
    int          issued     = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    control_word_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .step         (step),
        .done         (done),
        .reg_load     (reg_load),
        .bus_drive    (bus_drive),
        .mem_write    (mem_write),
        .pc_increment (pc_increment),
        .pc_halt      (pc_halt),
        .step_reset   (step_reset),
        .alu_op       (alu_op)
    );

    cwd_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .step         (step),
        .done         (done),
        .reg_load     (reg_load),
        .bus_drive    (bus_drive),
        .mem_write    (mem_write),
        .pc_increment (pc_increment),
        .pc_halt      (pc_halt),
        .step_reset   (step_reset),
        .alu_op       (alu_op),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Idle cycles after a transaction: mostly none or short, now and then long,
    // with occasional back-to-back bursts
    function automatic int next_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left = burst_left - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // One command transaction, then an optional idle stretch with junk payload
    task automatic issue(input logic [7:0] opc, input logic [3:0] stp);
        int gap;
        start  <= 1'b1;
        opcode <= opc;
        step   <= stp;
        do @(posedge clk); while (busy);
        issued = issued + 1;
        gap    = next_gap();
        if (gap > 0)
        begin
            start  <= 1'b0;
            opcode <= 8'($urandom);
            step   <= 4'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [7:0] opc;
        int         last_step;
        int         mode;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            issue(DIRECTED[i][11:4], DIRECTED[i][3:0]);

        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 6)
            begin
                // a whole instruction walk: fetch, then execute steps in order
                opc       = 8'($urandom_range(0, OP_PAST_TABLE));
                last_step = $urandom_range(cwd_pkg::STEP_EXEC_2, cwd_pkg::STEP_EXEC_6 + 1);
                for (int s = 0; s <= last_step; s++)
                    issue(opc, 4'(s));
            end
            else if (mode < 8)
            begin
                issue(8'($urandom_range(0, OP_PAST_TABLE)), 4'($urandom));
            end
            else
            begin
                issue(8'($urandom), 4'($urandom));
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
